// File: hdl/lrast_pkg.sv
`default_nettype none

package lrast_pkg;

    // Largest image side the block supports; a larger register value acts as this.
    localparam int MAX_DIM = 2048;

    // Field widths.
    localparam int COORD_W = $clog2(MAX_DIM);
    localparam int CFG_W   = 12;
    localparam int IN_W    = 13;
    localparam int COLOR_W = 24;
    localparam int STATUS_W = 2;

    // Internal arithmetic widths.
    localparam int CMP_W = IN_W + 1;
    localparam int DEC_W = COORD_W + 3;
    localparam int INC_W = COORD_W + 2;

    // Configuration register indexes and reset value.
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     IMAGE_DIM_RESET  = 12'd2048;

    // Input function codes.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_PIXEL = 2'd0,
        STATUS_IDLE  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    // Line parameters worked out from a start item's endpoints.
    typedef struct packed {
        logic                      in_range;
        logic                      y_major;
        logic [COORD_W-1:0]        major_pos;
        logic [COORD_W-1:0]        minor_pos;
        logic [COORD_W-1:0]        major_end;
        logic                      step_down;
        logic signed [DEC_W-1:0]   decision;
        logic signed [INC_W-1:0]   incr_no_step;
        logic signed [INC_W-1:0]   incr_with_step;
    } setup_t;

endpackage

`default_nettype wire

// File: hdl/lrast_setup.sv
`default_nettype none

module lrast_setup import lrast_pkg::*; (
    input  wire logic signed [IN_W-1:0]  start_x,
    input  wire logic signed [IN_W-1:0]  start_y,
    input  wire logic signed [IN_W-1:0]  end_x,
    input  wire logic signed [IN_W-1:0]  end_y,
    input  wire logic        [CFG_W-1:0] image_width,
    input  wire logic        [CFG_W-1:0] image_height,
    output setup_t                       setup
);

    localparam logic signed [CMP_W-1:0] DIM_LIMIT = CMP_W'(MAX_DIM);

    logic signed [CMP_W-1:0] w_ext, h_ext, w_lim, h_lim;
    logic signed [CMP_W-1:0] x0_ext, y0_ext, x1_ext, y1_ext;
    logic                    endpoints_ok;
    logic [COORD_W-1:0]      x0, y0, x1, y1;
    logic signed [COORD_W:0] dx, dy, ndx, ndy, dmn, ndmn;
    logic [COORD_W-1:0]      adx, ady;
    logic                    y_major, swap;
    logic [COORD_W-1:0]      a0, a1, b0, b1;
    logic [COORD_W-1:0]      maj0, maj1, min0, min1;
    logic [COORD_W-1:0]      dmaj, dmin;

    // Clamp the image size and check both endpoints against it.
    always_comb begin
        w_ext  = $signed({{(CMP_W-CFG_W){1'b0}}, image_width});
        h_ext  = $signed({{(CMP_W-CFG_W){1'b0}}, image_height});
        w_lim  = (w_ext > DIM_LIMIT) ? DIM_LIMIT : w_ext;
        h_lim  = (h_ext > DIM_LIMIT) ? DIM_LIMIT : h_ext;
        x0_ext = $signed({start_x[IN_W-1], start_x});
        y0_ext = $signed({start_y[IN_W-1], start_y});
        x1_ext = $signed({end_x[IN_W-1], end_x});
        y1_ext = $signed({end_y[IN_W-1], end_y});
        endpoints_ok = !x0_ext[CMP_W-1] && (x0_ext < w_lim)
                    && !y0_ext[CMP_W-1] && (y0_ext < h_lim)
                    && !x1_ext[CMP_W-1] && (x1_ext < w_lim)
                    && !y1_ext[CMP_W-1] && (y1_ext < h_lim);
    end

    // Pick the major axis and order the endpoints so the major coordinate rises.
    always_comb begin
        x0 = start_x[COORD_W-1:0];
        y0 = start_y[COORD_W-1:0];
        x1 = end_x[COORD_W-1:0];
        y1 = end_y[COORD_W-1:0];

        dx  = $signed({1'b0, x1}) - $signed({1'b0, x0});
        dy  = $signed({1'b0, y1}) - $signed({1'b0, y0});
        ndx = -dx;
        ndy = -dy;
        adx = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
        ady = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];

        // Ties and single points count as y-major.
        y_major = !(ady < adx);
        a0 = y_major ? y0 : x0;
        b0 = y_major ? x0 : y0;
        a1 = y_major ? y1 : x1;
        b1 = y_major ? x1 : y1;

        swap = (a0 > a1);
        maj0 = swap ? a1 : a0;
        min0 = swap ? b1 : b0;
        maj1 = swap ? a0 : a1;
        min1 = swap ? b0 : b1;

        dmaj = maj1 - maj0;
        dmn  = $signed({1'b0, min1}) - $signed({1'b0, min0});
        ndmn = -dmn;
        dmin = dmn[COORD_W] ? ndmn[COORD_W-1:0] : dmn[COORD_W-1:0];

        setup.in_range       = endpoints_ok;
        setup.y_major        = y_major;
        setup.major_pos      = maj0;
        setup.minor_pos      = min0;
        setup.major_end      = maj1;
        setup.step_down      = dmn[COORD_W];
        setup.decision       = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
        setup.incr_no_step   = $signed({1'b0, dmin, 1'b0});
        setup.incr_with_step = $signed({1'b0, dmin, 1'b0}) - $signed({1'b0, dmaj, 1'b0});
    end

endmodule

`default_nettype wire

// File: hdl/lrast_stepper.sv
`default_nettype none

module lrast_stepper import lrast_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 item_valid,
    input  wire logic                 item_func,
    input  wire logic [COLOR_W-1:0]   item_color,
    input  wire setup_t               setup,
    output logic                      item_take,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic [COORD_W-1:0]        m_out_x,
    output logic [COORD_W-1:0]        m_out_y,
    output logic [COLOR_W-1:0]        m_out_color,
    output logic                      m_last_pixel
);

    // Line state.
    logic                    line_active_reg, line_active_next;
    logic                    y_major_reg, y_major_next;
    logic [COORD_W-1:0]      major_pos_reg, major_pos_next;
    logic [COORD_W-1:0]      minor_pos_reg, minor_pos_next;
    logic [COORD_W-1:0]      major_end_reg, major_end_next;
    logic                    step_down_reg, step_down_next;
    logic signed [DEC_W-1:0] decision_reg, decision_next;
    logic signed [INC_W-1:0] incr_no_reg, incr_no_next;
    logic signed [INC_W-1:0] incr_with_reg, incr_with_next;
    logic [COLOR_W-1:0]      line_color_reg, line_color_next;

    // Result register.
    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic [COORD_W-1:0]      m_x_reg, m_x_next;
    logic [COORD_W-1:0]      m_y_reg, m_y_next;
    logic [COLOR_W-1:0]      m_color_reg, m_color_next;
    logic                    m_last_reg, m_last_next;

    logic                    emit_pixel;
    logic                    pixel_last;

    // An item is processed when the result register is free or being emptied.
    assign item_take = item_valid && (!m_valid_reg || m_ready);

    // Start setup or one Bresenham step, then form the result.
    always_comb begin
        line_active_next = line_active_reg;
        y_major_next     = y_major_reg;
        major_pos_next   = major_pos_reg;
        minor_pos_next   = minor_pos_reg;
        major_end_next   = major_end_reg;
        step_down_next   = step_down_reg;
        decision_next    = decision_reg;
        incr_no_next     = incr_no_reg;
        incr_with_next   = incr_with_reg;
        line_color_next  = line_color_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_x_next      = m_x_reg;
        m_y_next      = m_y_reg;
        m_color_next  = m_color_reg;
        m_last_next   = m_last_reg;

        emit_pixel = 1'b0;

        if (item_take) begin
            m_valid_next  = 1'b1;
            m_x_next      = '0;
            m_y_next      = '0;
            m_color_next  = '0;
            m_last_next   = 1'b0;
            if (item_func == FUNC_START) begin
                if (!setup.in_range) begin
                    line_active_next = 1'b0;
                    m_status_next    = STATUS_RANGE;
                end else begin
                    y_major_next    = setup.y_major;
                    major_pos_next  = setup.major_pos;
                    minor_pos_next  = setup.minor_pos;
                    major_end_next  = setup.major_end;
                    step_down_next  = setup.step_down;
                    decision_next   = setup.decision;
                    incr_no_next    = setup.incr_no_step;
                    incr_with_next  = setup.incr_with_step;
                    line_color_next = item_color;
                    emit_pixel      = 1'b1;
                end
            end else if (!line_active_reg) begin
                m_status_next = STATUS_IDLE;
            end else begin
                // Step the minor axis only when the decision term is positive.
                if (!decision_reg[DEC_W-1] && (decision_reg != '0)) begin
                    minor_pos_next = step_down_reg ? minor_pos_reg - COORD_W'(1)
                                                   : minor_pos_reg + COORD_W'(1);
                    decision_next  = decision_reg
                                   + {{(DEC_W-INC_W){incr_with_reg[INC_W-1]}}, incr_with_reg};
                end else begin
                    decision_next  = decision_reg
                                   + {{(DEC_W-INC_W){incr_no_reg[INC_W-1]}}, incr_no_reg};
                end
                major_pos_next = major_pos_reg + COORD_W'(1);
                emit_pixel     = 1'b1;
            end
        end

        // Emit the pixel at the updated position; the final pixel ends the line.
        pixel_last = (major_pos_next >= major_end_next);
        if (emit_pixel) begin
            m_status_next    = STATUS_PIXEL;
            m_x_next         = y_major_next ? minor_pos_next : major_pos_next;
            m_y_next         = y_major_next ? major_pos_next : minor_pos_next;
            m_color_next     = line_color_next;
            m_last_next      = pixel_last;
            line_active_next = !pixel_last;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            line_active_reg <= line_active_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Line parameters and result payload.
    always_ff @(posedge aclk) begin
        y_major_reg    <= y_major_next;
        major_pos_reg  <= major_pos_next;
        minor_pos_reg  <= minor_pos_next;
        major_end_reg  <= major_end_next;
        step_down_reg  <= step_down_next;
        decision_reg   <= decision_next;
        incr_no_reg    <= incr_no_next;
        incr_with_reg  <= incr_with_next;
        line_color_reg <= line_color_next;
        m_status_reg   <= m_status_next;
        m_x_reg        <= m_x_next;
        m_y_reg        <= m_y_next;
        m_color_reg    <= m_color_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_out_x      = m_x_reg;
    assign m_out_y      = m_y_reg;
    assign m_out_color  = m_color_reg;
    assign m_last_pixel = m_last_reg;

    // A pending final pixel means no line is left running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == STATUS_PIXEL && m_last_reg) |-> !line_active_reg)
        else $error("line still active after its final pixel");

    // A running line has not yet reached its end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        line_active_reg |-> (major_pos_reg < major_end_reg))
        else $error("active line at or past its end");

    // An idle report is only given when no line is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == STATUS_IDLE) |-> !line_active_reg)
        else $error("idle status while a line is active");

    // Non-pixel results carry all-zero payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != STATUS_PIXEL)
            |-> (m_x_reg == '0 && m_y_reg == '0 && m_color_reg == '0 && !m_last_reg))
        else $error("non-pixel result with nonzero payload");

endmodule

`default_nettype wire

// File: hdl/integer_line_rasterizer.sv
`default_nettype none

// Bresenham line rasterizer. A start transfer (func 0) checks both endpoints
// against the configured image size, picks the major axis and returns the
// first pixel or a range status; each step transfer (func 1) returns the
// next pixel, with last_pixel set on the line's end point, or an idle status
// if no line runs. Every input transfer yields exactly one result transfer.
// The block takes one transfer per clock unless the result channel stalls;
// results pass the input register, then the result register, with the start
// path (range check, axis choice, endpoint swap, decision term) between them.
// Write image_width and image_height only while no transfer is in flight.
module integer_line_rasterizer import lrast_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Configuration write port.
    input  wire logic                   cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    // Input channel.
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_func,
    input  wire logic signed [IN_W-1:0] s_start_x,
    input  wire logic signed [IN_W-1:0] s_start_y,
    input  wire logic signed [IN_W-1:0] s_end_x,
    input  wire logic signed [IN_W-1:0] s_end_y,
    input  wire logic [COLOR_W-1:0]     s_pixel_color,
    // Result channel.
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [STATUS_W-1:0]         m_status,
    output logic [COORD_W-1:0]          m_out_x,
    output logic [COORD_W-1:0]          m_out_y,
    output logic [COLOR_W-1:0]          m_out_color,
    output logic                        m_last_pixel
);

    logic [CFG_W-1:0]       image_width_reg, image_height_reg;
    logic                   in_valid_reg;
    logic                   func_reg;
    logic signed [IN_W-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [COLOR_W-1:0]     color_reg;
    logic                   item_take;
    setup_t                 setup;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMAGE_DIM_RESET;
            image_height_reg <= IMAGE_DIM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
            endcase
        end
    end

    // Input register: refilled whenever it is empty or its item moves on.
    assign s_ready = !in_valid_reg || item_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg    <= s_func;
            start_x_reg <= s_start_x;
            start_y_reg <= s_start_y;
            end_x_reg   <= s_end_x;
            end_y_reg   <= s_end_y;
            color_reg   <= s_pixel_color;
        end
    end

    // Line setup for start items.
    lrast_setup u_setup (
        .start_x      (start_x_reg),
        .start_y      (start_y_reg),
        .end_x        (end_x_reg),
        .end_y        (end_y_reg),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .setup        (setup)
    );

    // Line state, stepping and result register.
    lrast_stepper u_stepper (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (in_valid_reg),
        .item_func    (func_reg),
        .item_color   (color_reg),
        .setup        (setup),
        .item_take    (item_take),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_out_x      (m_out_x),
        .m_out_y      (m_out_y),
        .m_out_color  (m_out_color),
        .m_last_pixel (m_last_pixel)
    );

endmodule

`default_nettype wire
